[hw/rtl/trsp_pkg.sv]
// Package: phase encoding, role and event codes, tag bytes, result payload type.
package trsp_pkg;

  typedef enum logic [3:0] {
    PH_HT, PH_HTYPE, PH_HV, PH_HVER, PH_TAG, PH_NAME, PH_WORD, PH_BOOL,
    PH_TEXT, PH_ELEM, PH_SUM, PH_SKIP, PH_ZWAIT, PH_EOF, PH_ERR, PH_ERRHDR
  } phase_t;

  localparam logic [3:0] ROLE_HEADER   = 4'd0;
  localparam logic [3:0] ROLE_TAG      = 4'd1;
  localparam logic [3:0] ROLE_NAME     = 4'd2;
  localparam logic [3:0] ROLE_NAME_END = 4'd3;
  localparam logic [3:0] ROLE_VALUE    = 4'd4;
  localparam logic [3:0] ROLE_TEXT     = 4'd5;
  localparam logic [3:0] ROLE_TEXT_END = 4'd6;
  localparam logic [3:0] ROLE_ELEM     = 4'd7;
  localparam logic [3:0] ROLE_SUM      = 4'd8;
  localparam logic [3:0] ROLE_SUM_END  = 4'd9;
  localparam logic [3:0] ROLE_BLOB     = 4'd10;
  localparam logic [3:0] ROLE_IGNORED  = 4'd11;

  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_BEGIN    = 4'd1;
  localparam logic [3:0] EV_END      = 4'd2;
  localparam logic [3:0] EV_FLOAT    = 4'd3;
  localparam logic [3:0] EV_INT      = 4'd4;
  localparam logic [3:0] EV_BOOL     = 4'd5;
  localparam logic [3:0] EV_STRING   = 4'd6;
  localparam logic [3:0] EV_FBLOCK   = 4'd7;
  localparam logic [3:0] EV_U16BLOCK = 4'd8;
  localparam logic [3:0] EV_BLOB     = 4'd9;
  localparam logic [3:0] EV_BLOBREF  = 4'd10;
  localparam logic [3:0] EV_EOF      = 4'd11;
  localparam logic [3:0] EV_ERROR    = 4'd12;

  localparam logic [7:0] TAG_Z = 8'h5A;
  localparam logic [7:0] TAG_B = 8'h42;
  localparam logic [7:0] TAG_E = 8'h45;
  localparam logic [7:0] TAG_f = 8'h66;
  localparam logic [7:0] TAG_i = 8'h69;
  localparam logic [7:0] TAG_b = 8'h62;
  localparam logic [7:0] TAG_s = 8'h73;
  localparam logic [7:0] TAG_F = 8'h46;
  localparam logic [7:0] TAG_6 = 8'h36;
  localparam logic [7:0] TAG_O = 8'h4F;
  localparam logic [7:0] TAG_T = 8'h54;
  localparam logic [7:0] TAG_V = 8'h56;
  localparam logic [31:0] SIZE_REF = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]         byte_role;
    logic [7:0]         echo_byte;
    logic [3:0]         event_kind;
    logic               event_done;
    logic signed [31:0] value_word;
    logic               value_valid;
    logic [31:0]        element_word;
    logic               element_valid;
    logic [31:0]        blob_start;
    logic               header_ok;
  } result_t;

endpackage

[hw/rtl/trsp_in_if.sv]
// Input channel interface: one file byte or end mark per beat.
interface trsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

[hw/rtl/trsp_out_if.sv]
// Result channel interface: one classified result per beat.
interface trsp_out_if;
  logic                valid;
  logic                ready;
  trsp_pkg::result_t   res;
  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

[hw/rtl/tagged_record_stream_parser.sv]
// Top level: input register, parser core and result register.
// One byte (or end mark) per beat, one result per beat; a beat can be taken
// every cycle while the result register is free or being read. The input
// register feeds the core logic, whose result lands in the output register.
// in_ready is high while the input register is empty or drains this cycle.
module tagged_record_stream_parser #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  trsp_in_if.sink    in_ch,
  trsp_out_if.source out_ch
);

  logic       ivld_r;
  logic [7:0] ibyte_r;
  logic       ieos_r;
  logic       ovld_r;
  trsp_pkg::result_t ores_r, core_res;
  logic       step, stage_free;

  assign step       = ivld_r && (!ovld_r || out_ch.ready);
  assign stage_free = !ivld_r || step;
  assign in_ch.ready = stage_free;

  trsp_core #(.POSITION_WIDTH(POSITION_WIDTH)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (ibyte_r),
    .end_of_stream (ieos_r),
    .res           (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      if (stage_free) ivld_r <= in_ch.valid;
      if (step) ovld_r <= 1'b1;
      else if (out_ch.ready) ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && in_ch.valid) begin
      ibyte_r <= in_ch.data_byte;
      ieos_r  <= in_ch.end_of_stream;
    end
    if (step) ores_r <= core_res;
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.res   = ores_r;

endmodule

[hw/rtl/trsp_core.sv]
// Parser state and next-result logic for one byte per cycle while step is high.
module trsp_core #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data_byte,
  input  logic               end_of_stream,
  output trsp_pkg::result_t  res
);

  trsp_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]                tag_r, tag_nxt;
  logic [31:0]               word_r, word_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic [31:0]               rem_r, rem_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [31:0]               bsize_r, bsize_nxt;
  logic [31:0]               bstart_r, bstart_nxt;

  logic [31:0] asm_word;
  logic [1:0]  cnt_inc;
  logic        got4, got2, fail;
  logic [POSITION_WIDTH-1:0] pos_inc;

  always_comb begin
    asm_word = word_r | ({24'd0, data_byte} << {cnt_r, 3'd0});
    cnt_inc  = cnt_r + 2'd1;
    got4     = (cnt_r == 2'd3);
    got2     = (cnt_r == 2'd1);
    pos_inc  = pos_r + {{(POSITION_WIDTH-1){1'b0}}, 1'b1};
  end

  always_comb begin
    phase_nxt  = phase_r;
    tag_nxt    = tag_r;
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    bsize_nxt  = bsize_r;
    bstart_nxt = bstart_r;
    pos_nxt    = end_of_stream ? pos_r : pos_inc;
    fail       = 1'b0;
    res = '0;
    res.byte_role = trsp_pkg::ROLE_IGNORED;

    if (phase_r == trsp_pkg::PH_ERR || phase_r == trsp_pkg::PH_ERRHDR) begin
      res.event_kind = trsp_pkg::EV_ERROR;
    end else if (phase_r == trsp_pkg::PH_EOF) begin
      res.event_kind = trsp_pkg::EV_NONE;
    end else if (end_of_stream) begin
      if (phase_r == trsp_pkg::PH_ZWAIT) begin
        res.event_kind = trsp_pkg::EV_EOF;
        res.event_done = 1'b1;
        phase_nxt = trsp_pkg::PH_EOF;
      end else begin
        fail = 1'b1;
      end
    end else begin
      case (phase_r)
        trsp_pkg::PH_HT: begin
          res.byte_role = trsp_pkg::ROLE_HEADER;
          if (data_byte == trsp_pkg::TAG_T) phase_nxt = trsp_pkg::PH_HTYPE;
          else fail = 1'b1;
        end
        trsp_pkg::PH_HTYPE: begin
          res.byte_role = trsp_pkg::ROLE_HEADER;
          if (data_byte == 8'd0) phase_nxt = trsp_pkg::PH_HV;
        end
        trsp_pkg::PH_HV: begin
          res.byte_role = trsp_pkg::ROLE_HEADER;
          if (data_byte == trsp_pkg::TAG_V) begin
            phase_nxt = trsp_pkg::PH_HVER;
            word_nxt  = '0;
            cnt_nxt   = '0;
          end else fail = 1'b1;
        end
        trsp_pkg::PH_HVER: begin
          res.byte_role = trsp_pkg::ROLE_HEADER;
          word_nxt = asm_word;
          cnt_nxt  = cnt_inc;
          if (got4) begin
            res.value_word  = asm_word;
            res.value_valid = 1'b1;
            word_nxt  = '0;
            phase_nxt = trsp_pkg::PH_TAG;
          end
        end
        trsp_pkg::PH_TAG: begin
          res.byte_role = trsp_pkg::ROLE_TAG;
          tag_nxt  = data_byte;
          word_nxt = '0;
          cnt_nxt  = '0;
          if (data_byte == trsp_pkg::TAG_Z) phase_nxt = trsp_pkg::PH_ZWAIT;
          else if (data_byte == trsp_pkg::TAG_E) begin
            res.event_kind = trsp_pkg::EV_END;
            res.event_done = 1'b1;
          end else if (data_byte == trsp_pkg::TAG_B || data_byte == trsp_pkg::TAG_f ||
                       data_byte == trsp_pkg::TAG_i || data_byte == trsp_pkg::TAG_b ||
                       data_byte == trsp_pkg::TAG_s || data_byte == trsp_pkg::TAG_F ||
                       data_byte == trsp_pkg::TAG_6 || data_byte == trsp_pkg::TAG_O)
            phase_nxt = trsp_pkg::PH_NAME;
          else fail = 1'b1;
        end
        trsp_pkg::PH_NAME: begin
          if (data_byte != 8'd0) res.byte_role = trsp_pkg::ROLE_NAME;
          else begin
            res.byte_role = trsp_pkg::ROLE_NAME_END;
            if (tag_r == trsp_pkg::TAG_B) begin
              res.event_kind = trsp_pkg::EV_BEGIN;
              res.event_done = 1'b1;
              phase_nxt = trsp_pkg::PH_TAG;
            end else if (tag_r == trsp_pkg::TAG_b) phase_nxt = trsp_pkg::PH_BOOL;
            else if (tag_r == trsp_pkg::TAG_s) phase_nxt = trsp_pkg::PH_TEXT;
            else phase_nxt = trsp_pkg::PH_WORD;
          end
        end
        trsp_pkg::PH_WORD: begin
          res.byte_role = trsp_pkg::ROLE_VALUE;
          word_nxt = asm_word;
          cnt_nxt  = cnt_inc;
          if (got4) begin
            word_nxt = '0;
            res.value_word  = asm_word;
            res.value_valid = 1'b1;
            if (tag_r == trsp_pkg::TAG_f || tag_r == trsp_pkg::TAG_i) begin
              res.event_kind = (tag_r == trsp_pkg::TAG_f) ? trsp_pkg::EV_FLOAT
                                                          : trsp_pkg::EV_INT;
              res.event_done = 1'b1;
              phase_nxt = trsp_pkg::PH_TAG;
            end else if (tag_r == trsp_pkg::TAG_O) begin
              bsize_nxt = asm_word;
              phase_nxt = trsp_pkg::PH_SUM;
            end else if (asm_word[31]) begin
              fail = 1'b1;
            end else if (asm_word == 32'd0) begin
              res.event_kind = (tag_r == trsp_pkg::TAG_F) ? trsp_pkg::EV_FBLOCK
                                                          : trsp_pkg::EV_U16BLOCK;
              res.event_done = 1'b1;
              phase_nxt = trsp_pkg::PH_TAG;
            end else begin
              rem_nxt   = asm_word;
              phase_nxt = trsp_pkg::PH_ELEM;
            end
          end
        end
        trsp_pkg::PH_BOOL: begin
          res.byte_role = trsp_pkg::ROLE_VALUE;
          if (data_byte <= 8'd1) begin
            res.event_kind  = trsp_pkg::EV_BOOL;
            res.event_done  = 1'b1;
            res.value_word  = {24'd0, data_byte};
            res.value_valid = 1'b1;
            phase_nxt = trsp_pkg::PH_TAG;
          end else fail = 1'b1;
        end
        trsp_pkg::PH_TEXT: begin
          if (data_byte != 8'd0) res.byte_role = trsp_pkg::ROLE_TEXT;
          else begin
            res.byte_role  = trsp_pkg::ROLE_TEXT_END;
            res.event_kind = trsp_pkg::EV_STRING;
            res.event_done = 1'b1;
            phase_nxt = trsp_pkg::PH_TAG;
          end
        end
        trsp_pkg::PH_ELEM: begin
          res.byte_role = trsp_pkg::ROLE_ELEM;
          word_nxt = asm_word;
          cnt_nxt  = cnt_inc;
          if ((tag_r == trsp_pkg::TAG_F) ? got4 : got2) begin
            cnt_nxt  = '0;
            word_nxt = '0;
            res.element_word  = asm_word;
            res.element_valid = 1'b1;
            rem_nxt = rem_r - 32'd1;
            if (rem_r == 32'd1) begin
              res.event_kind = (tag_r == trsp_pkg::TAG_F) ? trsp_pkg::EV_FBLOCK
                                                          : trsp_pkg::EV_U16BLOCK;
              res.event_done = 1'b1;
              phase_nxt = trsp_pkg::PH_TAG;
            end
          end
        end
        trsp_pkg::PH_SUM: begin
          if (data_byte != 8'd0) res.byte_role = trsp_pkg::ROLE_SUM;
          else begin
            res.byte_role = trsp_pkg::ROLE_SUM_END;
            if (bsize_r == trsp_pkg::SIZE_REF) begin
              res.event_kind = trsp_pkg::EV_BLOBREF;
              res.event_done = 1'b1;
              res.value_word = bsize_r;
              phase_nxt = trsp_pkg::PH_TAG;
            end else if (bsize_r[31]) begin
              fail = 1'b1;
            end else begin
              bstart_nxt = 32'(pos_inc);
              if (bsize_r == 32'd0) begin
                res.event_kind = trsp_pkg::EV_BLOB;
                res.event_done = 1'b1;
                res.blob_start = 32'(pos_inc);
                phase_nxt = trsp_pkg::PH_TAG;
              end else begin
                rem_nxt   = bsize_r;
                phase_nxt = trsp_pkg::PH_SKIP;
              end
            end
          end
        end
        trsp_pkg::PH_SKIP: begin
          res.byte_role = trsp_pkg::ROLE_BLOB;
          rem_nxt = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            res.event_kind = trsp_pkg::EV_BLOB;
            res.event_done = 1'b1;
            res.value_word = bsize_r;
            res.blob_start = bstart_r;
            phase_nxt = trsp_pkg::PH_TAG;
          end
        end
        default: begin
          res.byte_role = trsp_pkg::ROLE_IGNORED;
          fail = 1'b1;
        end
      endcase
    end

    if (fail) begin
      phase_nxt = (phase_r <= trsp_pkg::PH_HVER) ? trsp_pkg::PH_ERRHDR : trsp_pkg::PH_ERR;
      res.event_kind    = trsp_pkg::EV_ERROR;
      res.event_done    = 1'b1;
      res.value_word    = '0;
      res.value_valid   = 1'b0;
      res.element_word  = '0;
      res.element_valid = 1'b0;
      res.blob_start    = '0;
      if (end_of_stream) res.byte_role = trsp_pkg::ROLE_IGNORED;
    end
    res.echo_byte = (res.byte_role != trsp_pkg::ROLE_IGNORED && !end_of_stream)
                    ? data_byte : 8'd0;
    res.header_ok = (phase_nxt >= trsp_pkg::PH_TAG) && (phase_nxt != trsp_pkg::PH_ERRHDR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= trsp_pkg::PH_HT;
      tag_r    <= '0;
      word_r   <= '0;
      cnt_r    <= '0;
      rem_r    <= '0;
      pos_r    <= '0;
      bsize_r  <= '0;
      bstart_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tag_r    <= tag_nxt;
      word_r   <= word_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      bsize_r  <= bsize_nxt;
      bstart_r <= bstart_nxt;
    end
  end

endmodule

[tb/sv/tb_trsp_channels.sv]
// Testbench-side note: channel interfaces come from the RTL; this file holds stimulus beat type.
`timescale 1ns / 100ps
package tb_trsp_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } stim_beat_t;
endpackage

[tb/sv/testbench.sv]
// Top testbench: drives file bytes, predicts parser results, checks every beat.
`timescale 1ns / 100ps
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  trsp_in_if  in_ch();
  trsp_out_if out_ch();

  tagged_record_stream_parser i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  tb_trsp_pkg::stim_beat_t pending_beats[$];
  trsp_pkg::result_t       expected_results[$];
  int         fail_count = 0;
  bit         in_taken = 1'b0;

  // parser predictor state
  trsp_pkg::phase_t p_phase;
  logic [7:0]  p_tag;
  logic [31:0] p_word;
  logic [1:0]  p_nbytes;
  logic [31:0] p_remain;
  logic [31:0] p_pos;
  logic [31:0] p_blob_size;
  logic [31:0] p_blob_start;

  function automatic bit gather_byte(logic [7:0] b, logic [1:0] need);
    p_word = p_word | ({24'd0, b} << (8 * p_nbytes));
    p_nbytes = p_nbytes + 2'd1;
    if (p_nbytes == need) begin
      p_nbytes = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit bool_known_tag(logic [7:0] b);
    return b inside {trsp_pkg::TAG_B, trsp_pkg::TAG_f, trsp_pkg::TAG_i, trsp_pkg::TAG_b,
                     trsp_pkg::TAG_s, trsp_pkg::TAG_F, trsp_pkg::TAG_6, trsp_pkg::TAG_O};
  endfunction

  function automatic trsp_pkg::result_t parse_beat(tb_trsp_pkg::stim_beat_t s);
    trsp_pkg::result_t r;
    logic [7:0] b;
    bit fail;
    b = s.data_byte;
    fail = 0;
    r = '0;
    r.byte_role = trsp_pkg::ROLE_IGNORED;
    r.event_kind = trsp_pkg::EV_NONE;
    if (p_phase == trsp_pkg::PH_ERR || p_phase == trsp_pkg::PH_ERRHDR) begin
      r.event_kind = trsp_pkg::EV_ERROR;
    end else if (p_phase == trsp_pkg::PH_EOF) begin
    end else if (s.end_of_stream) begin
      if (p_phase == trsp_pkg::PH_ZWAIT) begin
        r.event_kind = trsp_pkg::EV_EOF; r.event_done = 1; p_phase = trsp_pkg::PH_EOF;
      end else fail = 1;
    end else begin
      case (p_phase)
        trsp_pkg::PH_HT: begin
          r.byte_role = trsp_pkg::ROLE_HEADER;
          if (b == trsp_pkg::TAG_T) p_phase = trsp_pkg::PH_HTYPE; else fail = 1;
        end
        trsp_pkg::PH_HTYPE: begin
          r.byte_role = trsp_pkg::ROLE_HEADER;
          if (b == 0) p_phase = trsp_pkg::PH_HV;
        end
        trsp_pkg::PH_HV: begin
          r.byte_role = trsp_pkg::ROLE_HEADER;
          if (b == trsp_pkg::TAG_V) begin
            p_phase = trsp_pkg::PH_HVER; p_word = 0; p_nbytes = '0;
          end else fail = 1;
        end
        trsp_pkg::PH_HVER: begin
          r.byte_role = trsp_pkg::ROLE_HEADER;
          if (gather_byte(b, 2'd0)) begin
            r.value_word = p_word; r.value_valid = 1; p_word = 0;
            p_phase = trsp_pkg::PH_TAG;
          end
        end
        trsp_pkg::PH_TAG: begin
          r.byte_role = trsp_pkg::ROLE_TAG;
          p_tag = b; p_word = 0; p_nbytes = '0;
          if (b == trsp_pkg::TAG_Z) p_phase = trsp_pkg::PH_ZWAIT;
          else if (b == trsp_pkg::TAG_E) begin
            r.event_kind = trsp_pkg::EV_END; r.event_done = 1;
          end else if (bool_known_tag(b)) p_phase = trsp_pkg::PH_NAME;
          else fail = 1;
        end
        trsp_pkg::PH_NAME: begin
          if (b != 0) r.byte_role = trsp_pkg::ROLE_NAME;
          else begin
            r.byte_role = trsp_pkg::ROLE_NAME_END;
            if (p_tag == trsp_pkg::TAG_B) begin
              r.event_kind = trsp_pkg::EV_BEGIN; r.event_done = 1;
              p_phase = trsp_pkg::PH_TAG;
            end else if (p_tag == trsp_pkg::TAG_b) p_phase = trsp_pkg::PH_BOOL;
            else if (p_tag == trsp_pkg::TAG_s) p_phase = trsp_pkg::PH_TEXT;
            else p_phase = trsp_pkg::PH_WORD;
          end
        end
        trsp_pkg::PH_WORD: begin
          r.byte_role = trsp_pkg::ROLE_VALUE;
          if (gather_byte(b, 2'd0)) begin
            r.value_word = p_word; r.value_valid = 1; p_word = 0;
            if (p_tag == trsp_pkg::TAG_f || p_tag == trsp_pkg::TAG_i) begin
              r.event_kind = (p_tag == trsp_pkg::TAG_f) ? trsp_pkg::EV_FLOAT
                                                        : trsp_pkg::EV_INT;
              r.event_done = 1; p_phase = trsp_pkg::PH_TAG;
            end else if (p_tag == trsp_pkg::TAG_O) begin
              p_blob_size = r.value_word; p_phase = trsp_pkg::PH_SUM;
            end else if (r.value_word[31]) fail = 1;
            else if (r.value_word == 0) begin
              r.event_kind = (p_tag == trsp_pkg::TAG_F) ? trsp_pkg::EV_FBLOCK
                                                        : trsp_pkg::EV_U16BLOCK;
              r.event_done = 1; p_phase = trsp_pkg::PH_TAG;
            end else begin
              p_remain = r.value_word; p_phase = trsp_pkg::PH_ELEM;
            end
          end
        end
        trsp_pkg::PH_BOOL: begin
          r.byte_role = trsp_pkg::ROLE_VALUE;
          if (b <= 1) begin
            r.event_kind = trsp_pkg::EV_BOOL; r.event_done = 1;
            r.value_word = {24'd0, b};
            r.value_valid = 1; p_phase = trsp_pkg::PH_TAG;
          end else fail = 1;
        end
        trsp_pkg::PH_TEXT: begin
          if (b != 0) r.byte_role = trsp_pkg::ROLE_TEXT;
          else begin
            r.byte_role = trsp_pkg::ROLE_TEXT_END; r.event_kind = trsp_pkg::EV_STRING;
            r.event_done = 1; p_phase = trsp_pkg::PH_TAG;
          end
        end
        trsp_pkg::PH_ELEM: begin
          r.byte_role = trsp_pkg::ROLE_ELEM;
          if (gather_byte(b, (p_tag == trsp_pkg::TAG_F) ? 2'd0 : 2'd2)) begin
            r.element_word = p_word; r.element_valid = 1; p_word = 0;
            p_remain = p_remain - 32'd1;
            if (p_remain == 0) begin
              r.event_kind = (p_tag == trsp_pkg::TAG_F) ? trsp_pkg::EV_FBLOCK
                                                        : trsp_pkg::EV_U16BLOCK;
              r.event_done = 1; p_phase = trsp_pkg::PH_TAG;
            end
          end
        end
        trsp_pkg::PH_SUM: begin
          if (b != 0) r.byte_role = trsp_pkg::ROLE_SUM;
          else begin
            r.byte_role = trsp_pkg::ROLE_SUM_END;
            if (p_blob_size == trsp_pkg::SIZE_REF) begin
              r.event_kind = trsp_pkg::EV_BLOBREF; r.event_done = 1;
              r.value_word = p_blob_size; p_phase = trsp_pkg::PH_TAG;
            end else if (p_blob_size[31]) fail = 1;
            else begin
              p_blob_start = p_pos + 32'd1;
              if (p_blob_size == 0) begin
                r.event_kind = trsp_pkg::EV_BLOB; r.event_done = 1;
                r.blob_start = p_blob_start; p_phase = trsp_pkg::PH_TAG;
              end else begin
                p_remain = p_blob_size; p_phase = trsp_pkg::PH_SKIP;
              end
            end
          end
        end
        trsp_pkg::PH_SKIP: begin
          r.byte_role = trsp_pkg::ROLE_BLOB;
          p_remain = p_remain - 32'd1;
          if (p_remain == 0) begin
            r.event_kind = trsp_pkg::EV_BLOB; r.event_done = 1;
            r.value_word = p_blob_size;
            r.blob_start = p_blob_start; p_phase = trsp_pkg::PH_TAG;
          end
        end
        default: begin
          r.byte_role = trsp_pkg::ROLE_IGNORED; fail = 1;
        end
      endcase
    end
    if (fail) begin
      p_phase = (p_phase <= trsp_pkg::PH_HVER) ? trsp_pkg::PH_ERRHDR : trsp_pkg::PH_ERR;
      r.event_kind = trsp_pkg::EV_ERROR; r.event_done = 1; r.value_word = 0;
      r.value_valid = 0; r.element_word = 0; r.element_valid = 0; r.blob_start = 0;
      if (s.end_of_stream) r.byte_role = trsp_pkg::ROLE_IGNORED;
    end
    if (!s.end_of_stream) p_pos = p_pos + 32'd1;
    r.echo_byte = (r.byte_role != trsp_pkg::ROLE_IGNORED && !s.end_of_stream) ? b : 8'd0;
    r.header_ok = (p_phase >= trsp_pkg::PH_TAG && p_phase != trsp_pkg::PH_ERRHDR);
    return r;
  endfunction

  task automatic put_byte(logic [7:0] b);
    pending_beats.push_back('{data_byte: b, end_of_stream: 1'b0});
  endtask

  task automatic put_end();
    pending_beats.push_back('{data_byte: 8'($urandom), end_of_stream: 1'b1});
  endtask

  task automatic put_word(logic [31:0] w, int n);
    for (int k = 0; k < n; k++) put_byte(w[8*k +: 8]);
  endtask

  task automatic put_text(int len);
    for (int k = 0; k < len; k++) put_byte(8'($urandom_range(1, 255)));
    put_byte(8'd0);
  endtask

  task automatic put_header(logic [31:0] ver);
    put_byte(trsp_pkg::TAG_T); put_text($urandom_range(0, 4));
    put_byte(trsp_pkg::TAG_V); put_word(ver, 4);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one well-formed record with random content; a few carry deliberate faults
  task automatic put_record(bit allow_fault);
    logic [31:0] w;
    logic [7:0]  tg;
    int cnt;
    case ($urandom_range(0, 9))
      0: begin put_byte(trsp_pkg::TAG_B); put_text($urandom_range(0, 3)); end
      1: put_byte(trsp_pkg::TAG_E);
      2: begin
        put_byte(trsp_pkg::TAG_f); put_text($urandom_range(0, 3)); put_word(pick_word(), 4);
      end
      3: begin
        put_byte(trsp_pkg::TAG_i); put_text($urandom_range(0, 3)); put_word(pick_word(), 4);
      end
      4: begin
        put_byte(trsp_pkg::TAG_b); put_text($urandom_range(0, 3));
        put_byte(allow_fault ? 8'($urandom) : 8'($urandom_range(0, 1)));
      end
      5: begin put_byte(trsp_pkg::TAG_s); put_text($urandom_range(0, 6)); end
      6, 7: begin
        cnt = $urandom_range(0, 4);
        tg = (($urandom & 1) != 0) ? trsp_pkg::TAG_F : trsp_pkg::TAG_6;
        put_byte(tg); put_text($urandom_range(0, 2));
        w = allow_fault ? (32'h8000_0000 | $urandom) : 32'(cnt);
        put_word(w, 4);
        if (!allow_fault)
          for (int k = 0; k < cnt * ((tg == trsp_pkg::TAG_F) ? 4 : 2); k++)
            put_byte(8'($urandom));
      end
      default: begin
        cnt = $urandom_range(0, 6);
        put_byte(trsp_pkg::TAG_O); put_text($urandom_range(0, 2));
        if (allow_fault) w = 32'h8000_0000 | ($urandom & 32'hFFFF_FFFE);
        else if ($urandom_range(0, 3) == 0) w = trsp_pkg::SIZE_REF;
        else w = 32'(cnt);
        put_word(w, 4); put_text($urandom_range(0, 3));
        if (!allow_fault && w != trsp_pkg::SIZE_REF)
          for (int k = 0; k < cnt; k++) put_byte(8'($urandom));
      end
    endcase
  endtask

  // driver: bursts and gaps, changes on falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= pending_beats[0].data_byte;
        in_ch.end_of_stream <= pending_beats[0].end_of_stream;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
        end else burst_left = burst_left - 1;
      end else in_ch.valid <= 1'b0;
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = stall_phase + 1;
    if (stall_phase[9]) out_ch.ready <= 1'b1;
    else out_ch.ready <= (($urandom_range(0, 3) != 0) || stall_phase[3:0] == 0);
  end

  // monitor: accept input, predict, check output
  int idle_cycles = 0;
  always @(posedge clk) begin
    trsp_pkg::result_t exp_r;
    bit out_taken;
    in_taken = 1'b0;
    if (rst_n) begin
      in_taken = in_ch.valid && in_ch.ready;
      out_taken = out_ch.valid && out_ch.ready;
      if (in_taken) expected_results.push_back(parse_beat(pending_beats.pop_front()));
      if (out_taken) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_ch.res);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_ch.res) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_ch.res);
            fail_count++;
          end
        end
      end
      if (in_taken || out_taken) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int bytes;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
    p_phase = trsp_pkg::PH_HT; p_tag = 0; p_word = 0; p_nbytes = '0;
    p_remain = 0; p_pos = 0; p_blob_size = 0; p_blob_start = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: full header and one record each of several kinds
    put_header(32'hFFFF_FFFF);
    put_byte(trsp_pkg::TAG_B); put_byte(8'h00); put_byte(trsp_pkg::TAG_E);
    put_byte(trsp_pkg::TAG_b); put_byte(8'h00); put_byte(8'h01);
    put_byte(trsp_pkg::TAG_6); put_byte(8'h00); put_word(32'd1, 4); put_word(32'hFFFF, 2);
    put_byte(trsp_pkg::TAG_O); put_byte(8'h00); put_word(32'd0, 4); put_byte(8'h00);
    // the parser has no restart: one long stream first, then faults late in it
    while (pending_beats.size() < 1560) put_record(1'b0);
    for (int k = 0; k < 4; k++) put_record(1'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: put_byte(8'($urandom));
      1: begin put_byte(trsp_pkg::TAG_Z); put_byte(8'($urandom)); end
      2: put_end();
      default: begin put_byte(trsp_pkg::TAG_Z); put_end(); end
    endcase
    for (int k = 0; k < 20; k++)
      if (($urandom & 1) != 0) put_end(); else put_byte(8'($urandom));
    wait (pending_beats.size() == 0);
    bytes = 0;
    while (expected_results.size() != 0 && bytes < WATCHDOG_LIMIT) begin
      @(posedge clk);
      bytes++;
    end
    repeat (5) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[tagged_record_stream_parser.f]
hw/rtl/trsp_pkg.sv
hw/rtl/trsp_in_if.sv
hw/rtl/trsp_out_if.sv
hw/rtl/trsp_core.sv
hw/rtl/tagged_record_stream_parser.sv
tb/sv/tb_trsp_channels.sv
tb/sv/testbench.sv
